// File: rtl/lof_pkg.sv
`timescale 1ns / 1ps

package lof_pkg;

    // fixed field widths of the stream items
    localparam int IDX_BITS   = 7;
    localparam int VAL_BITS   = 32;
    localparam int POS_BITS   = 8;
    localparam int SIZE_BITS  = 8;
    localparam int FIT_BITS   = 64;
    localparam int OP_BITS    = 2;
    localparam int TDATA_BITS = 56;

    // tdata layout of an input request
    localparam int ROW_LSB  = 0;
    localparam int COL_LSB  = ROW_LSB + IDX_BITS;
    localparam int VAL_LSB  = COL_LSB + IDX_BITS;
    localparam int GENE_LSB = VAL_LSB + VAL_BITS;

    typedef enum logic [OP_BITS-1:0] {
        OP_ENTRY   = 2'd0,
        OP_DIRECT  = 2'd1,
        OP_INVERSE = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        EV_IDLE,
        EV_ROW,
        EV_ROW_WAIT,
        EV_COL,
        EV_DRAIN,
        EV_DONE
    } t_eval_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_eval_stat;

endpackage

// File: rtl/lof_ram.sv
`timescale 1ns / 1ps

module lof_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/lof_eval.sv
`timescale 1ns / 1ps

module lof_eval #(
    parameter int MAX_ITEMS  = 128,
    parameter int ENTRY_BITS = 32,
    parameter int IW         = $clog2(MAX_ITEMS),
    parameter int NW         = $clog2(MAX_ITEMS + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [NW-1:0]               i_size,
    input  logic                        i_take,
    output lof_pkg::t_eval_stat         o_stat,
    output logic [lof_pkg::FIT_BITS-1:0] o_sum,
    output logic [IW-1:0]               o_order_raddr,
    input  logic [lof_pkg::POS_BITS-1:0] i_order_rdata,
    output logic [2*IW-1:0]             o_mat_raddr,
    input  logic [ENTRY_BITS-1:0]       i_mat_rdata
);

    localparam int FB = lof_pkg::FIT_BITS;
    localparam int PB = lof_pkg::POS_BITS;

    lof_pkg::t_eval_state r_state, n_state;
    logic [IW-1:0]        r_i, n_i;
    logic [IW-1:0]        r_j, n_j;
    logic [IW-1:0]        r_last, n_last;
    logic [PB-1:0]        r_a, n_a;
    logic                 r_a_ok, n_a_ok;
    logic [FB-1:0]        r_acc, n_acc;
    logic                 r_v1, r_v2;
    logic                 col_issue;
    logic                 b_ok;
    logic [FB-1:0]        weight_ext;

    assign b_ok       = 32'(i_order_rdata) < MAX_ITEMS;
    assign weight_ext = {{(FB - ENTRY_BITS){i_mat_rdata[ENTRY_BITS-1]}}, i_mat_rdata};
    assign o_mat_raddr = {IW'(r_a), IW'(i_order_rdata)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lof_pkg::EV_IDLE;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_acc   <= '0;
        end else begin
            r_state <= n_state;
            r_v1    <= col_issue;
            // stage two only counts pairs whose elements both index the matrix
            r_v2    <= r_v1 && r_a_ok && b_ok;
            r_acc   <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_j    <= n_j;
        r_last <= n_last;
        r_a    <= n_a;
        r_a_ok <= n_a_ok;
    end

    always_comb begin
        n_state       = r_state;
        n_i           = r_i;
        n_j           = r_j;
        n_last        = r_last;
        n_a           = r_a;
        n_a_ok        = r_a_ok;
        n_acc         = r_v2 ? r_acc + weight_ext : r_acc;
        col_issue     = 1'b0;
        o_order_raddr = r_j;
        unique case (r_state)
            lof_pkg::EV_IDLE: begin
                if (i_start) begin
                    n_acc  = '0;
                    n_i    = '0;
                    n_last = IW'(i_size - NW'(1));
                    if (i_size < NW'(2)) begin
                        n_state = lof_pkg::EV_DONE;
                    end else begin
                        n_state = lof_pkg::EV_ROW;
                    end
                end
            end
            lof_pkg::EV_ROW: begin
                o_order_raddr = r_i;
                n_state       = lof_pkg::EV_ROW_WAIT;
            end
            lof_pkg::EV_ROW_WAIT: begin
                n_a     = i_order_rdata;
                n_a_ok  = b_ok;
                n_j     = r_i + IW'(1);
                n_state = lof_pkg::EV_COL;
            end
            lof_pkg::EV_COL: begin
                o_order_raddr = r_j;
                col_issue     = 1'b1;
                n_j           = r_j + IW'(1);
                if (r_j == r_last) begin
                    n_i = r_i + IW'(1);
                    if (r_i + IW'(1) == r_last) begin
                        n_state = lof_pkg::EV_DRAIN;
                    end else begin
                        n_state = lof_pkg::EV_ROW;
                    end
                end
            end
            lof_pkg::EV_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = lof_pkg::EV_DONE;
                end
            end
            lof_pkg::EV_DONE: begin
                if (i_take) begin
                    n_state = lof_pkg::EV_IDLE;
                end
            end
            default: begin
                n_state = lof_pkg::EV_IDLE;
            end
        endcase
    end

    assign o_stat.busy = (r_state != lof_pkg::EV_IDLE);
    assign o_stat.done = (r_state == lof_pkg::EV_DONE);
    assign o_sum       = r_acc;

endmodule

// File: rtl/linear_ordering_fitness.sv
`timescale 1ns / 1ps

// Linear ordering objective. Requests on the s_axis channel either load one
// matrix weight (tuser = entry) or place one permutation element, directly
// (element at the next position) or inversely (next element stands at the
// given position). The request with tlast set among permutation requests
// starts scoring: the sum of weight[a][b] over all pairs with a ordered before
// b, emitted as one signed 64-bit request on m_axis.
// The configuration channel sets problem_size; write it only while idle.
// Weight and element requests are taken whenever no scoring is under way. The
// scoring of a size-n problem is bounded by the single read port of the weight
// memory (one weight per cycle within a row) and the fetch of each row element
// from the order memory, which pauses the weight reads between rows.
// s_axis_tready is low while scoring and until the total has moved into the
// output register; a stalled m_axis receiver holds that register while new
// weight and element requests are still taken.
// Reset clears the element count and output valid flag and sets problem_size
// to 2; memory contents are undefined until written and need no clearing.
module linear_ordering_fitness #(
    parameter int MAX_ITEMS  = 128,
    parameter int ENTRY_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,   // problem_size
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // row_index[6:0], column_index[13:7], entry_value[45:14], gene_value[52:46]
    input  logic [55:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser, // operation
    input  logic        s_axis_tlast, // last_gene
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata  // fitness
);

    localparam int IW = $clog2(MAX_ITEMS);
    localparam int NW = $clog2(MAX_ITEMS + 1);
    localparam int PB = lof_pkg::POS_BITS;
    localparam int XB = lof_pkg::IDX_BITS;

    logic [lof_pkg::SIZE_BITS-1:0] r_problem_size;
    logic [PB-1:0]                 r_pos;
    logic                          r_out_valid;
    logic [lof_pkg::FIT_BITS-1:0]  r_out_data;

    logic                     accept;
    lof_pkg::t_op             op;
    logic [XB-1:0]            row, col, gene;
    logic [ENTRY_BITS-1:0]    entry;
    logic                     is_elem;
    logic                     start;
    logic                     take;
    logic [NW-1:0]            size_sat;
    lof_pkg::t_eval_stat      stat;
    logic [lof_pkg::FIT_BITS-1:0] sum;

    logic                     mat_we;
    logic [2*IW-1:0]          mat_waddr, mat_raddr;
    logic [ENTRY_BITS-1:0]    mat_rdata;
    logic                     ord_we;
    logic [IW-1:0]            ord_waddr, ord_raddr;
    logic [PB-1:0]            ord_wdata, ord_rdata;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !stat.busy;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign op            = lof_pkg::t_op'(s_axis_tuser);
    assign row   = s_axis_tdata[lof_pkg::ROW_LSB +: XB];
    assign col   = s_axis_tdata[lof_pkg::COL_LSB +: XB];
    assign gene  = s_axis_tdata[lof_pkg::GENE_LSB +: XB];
    assign entry = s_axis_tdata[lof_pkg::VAL_LSB +: ENTRY_BITS];

    assign size_sat = (32'(r_problem_size) > MAX_ITEMS) ? NW'(MAX_ITEMS)
                                                        : NW'(r_problem_size);

    always_comb begin
        is_elem   = 1'b0;
        mat_we    = 1'b0;
        ord_we    = 1'b0;
        mat_waddr = {IW'(row), IW'(col)};
        ord_waddr = IW'(r_pos);
        ord_wdata = PB'(gene);
        unique case (op)
            lof_pkg::OP_ENTRY: begin
                mat_we = accept && (32'(row) < MAX_ITEMS) && (32'(col) < MAX_ITEMS);
            end
            lof_pkg::OP_DIRECT: begin
                is_elem = 1'b1;
                ord_we  = accept && (32'(r_pos) < MAX_ITEMS);
            end
            lof_pkg::OP_INVERSE: begin
                is_elem   = 1'b1;
                ord_waddr = IW'(gene);
                ord_wdata = r_pos;
                ord_we    = accept && (32'(gene) < MAX_ITEMS);
            end
            default: begin
                is_elem = 1'b0;
            end
        endcase
    end

    assign start = accept && is_elem && s_axis_tlast;
    assign take  = stat.done && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_problem_size <= lof_pkg::SIZE_BITS'(2);
            r_pos          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_problem_size <= i_cfg_data;
            end
            if (accept && is_elem) begin
                if (s_axis_tlast) begin
                    r_pos <= '0;
                end else if (r_pos != '1) begin
                    r_pos <= r_pos + PB'(1);
                end
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_data <= sum;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    lof_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (2 ** (2 * IW))
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (mat_we),
        .i_waddr (mat_waddr),
        .i_wdata (entry),
        .i_raddr (mat_raddr),
        .o_rdata (mat_rdata)
    );

    lof_ram #(
        .WIDTH (PB),
        .DEPTH (2 ** IW)
    ) u_order_ram (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (ord_waddr),
        .i_wdata (ord_wdata),
        .i_raddr (ord_raddr),
        .o_rdata (ord_rdata)
    );

    lof_eval #(
        .MAX_ITEMS  (MAX_ITEMS),
        .ENTRY_BITS (ENTRY_BITS),
        .IW         (IW),
        .NW         (NW)
    ) u_eval (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_size        (size_sat),
        .i_take        (take),
        .o_stat        (stat),
        .o_sum         (sum),
        .o_order_raddr (ord_raddr),
        .i_order_rdata (ord_rdata),
        .o_mat_raddr   (mat_raddr),
        .i_mat_rdata   (mat_rdata)
    );

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int OP_BITS    = lof_pkg::OP_BITS;
    localparam int IDX_BITS   = lof_pkg::IDX_BITS;
    localparam int VAL_BITS   = lof_pkg::VAL_BITS;
    localparam int POS_BITS   = lof_pkg::POS_BITS;
    localparam int SIZE_BITS  = lof_pkg::SIZE_BITS;
    localparam int FIT_BITS   = lof_pkg::FIT_BITS;
    localparam int TDATA_BITS = lof_pkg::TDATA_BITS;

    localparam int MAX_N = 128;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES = 64;
    localparam int LONG_HOLD = 1500;
    localparam int RANDOM_ITEMS = 575;
    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
    localparam int RX_OPEN = 0;
    localparam int RX_COIN = 1;
    localparam int RX_SLOW = 2;

    typedef struct {
        logic [OP_BITS-1:0]  op;
        logic [IDX_BITS-1:0] row;
        logic [IDX_BITS-1:0] col;
        logic [VAL_BITS-1:0] weight;
        logic [IDX_BITS-1:0] gene;
        logic                last_gene;
    } t_lof_request;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [SIZE_BITS-1:0]  i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [TDATA_BITS-1:0] s_axis_tdata = '0;
    logic [OP_BITS-1:0]    s_axis_tuser = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [FIT_BITS-1:0]   m_axis_tdata;

    linear_ordering_fitness #(
        .MAX_ITEMS  (MAX_N),
        .ENTRY_BITS (VAL_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // predicted block state, updated as requests are taken
    logic [VAL_BITS-1:0]  weight_seen [0:MAX_N*MAX_N-1];
    logic [POS_BITS-1:0]  order_seen [0:MAX_N-1];
    logic [POS_BITS-1:0]  count_seen = '0;
    logic [SIZE_BITS-1:0] size_seen = 8'd2;
    logic [FIT_BITS-1:0]  fitness_due [$];
    logic [FIT_BITS-1:0]  fitness_want;
    int                   mismatches = 0;

    // stimulus-side shadow so that no unwritten entry is ever read
    bit                   plan_set [0:MAX_N*MAX_N-1];
    logic [POS_BITS-1:0]  plan_order [0:MAX_N-1];
    logic [POS_BITS-1:0]  plan_count = '0;
    logic [SIZE_BITS-1:0] plan_size = 8'd2;
    logic [IDX_BITS-1:0]  perm_buf [0:MAX_N-1];
    t_lof_request         pending [$];
    int                   queued = 0;

    bit                   cfg_fire;
    bit                   in_fire;
    bit                   hold_armed = 1'b0;
    int                   hold_count = 0;
    int                   rx_mode = RX_OPEN;
    int                   rx_left = 0;
    int                   burst_left = 0;
    int                   gap_left = 0;
    t_lof_request         next_req;

    function automatic logic [FIT_BITS-1:0] pair_weight(logic [POS_BITS-1:0] a,
                                                        logic [POS_BITS-1:0] b);
        logic [VAL_BITS-1:0] w;
        if (a >= MAX_N || b >= MAX_N) return '0;
        w = weight_seen[{a[IDX_BITS-1:0], b[IDX_BITS-1:0]}];
        return {{(FIT_BITS-VAL_BITS){w[VAL_BITS-1]}}, w};
    endfunction

    function automatic void score_request(logic [OP_BITS-1:0] op, logic [IDX_BITS-1:0] row,
                                          logic [IDX_BITS-1:0] col, logic [VAL_BITS-1:0] value,
                                          logic [IDX_BITS-1:0] gene, logic mark);
        int                  span;
        logic [FIT_BITS-1:0] total;
        if (op == lof_pkg::OP_ENTRY) begin
            weight_seen[{row, col}] = value;
            return;
        end
        if (op == OP_UNUSED) return;
        if (op == lof_pkg::OP_DIRECT) begin
            if (count_seen < MAX_N) order_seen[count_seen[IDX_BITS-1:0]] = {1'b0, gene};
        end else begin
            order_seen[gene] = count_seen;
        end
        if (count_seen != 8'hff) count_seen++;
        if (!mark) return;
        span = (size_seen > MAX_N) ? MAX_N : size_seen;
        total = '0;
        for (int i = 0; i + 1 < span; i++)
            for (int j = i + 1; j < span; j++)
                total += pair_weight(order_seen[i], order_seen[j]);
        fitness_due.push_back(total);
        count_seen = '0;
    endfunction

    function automatic logic [VAL_BITS-1:0] fill_weight();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic void queue_entry(logic [IDX_BITS-1:0] row, logic [IDX_BITS-1:0] col,
                                        logic [VAL_BITS-1:0] value, logic mark);
        t_lof_request r;
        r.op = lof_pkg::OP_ENTRY;
        r.row = row;
        r.col = col;
        r.weight = value;
        r.gene = IDX_BITS'($urandom_range(0, 127));
        r.last_gene = mark;
        pending.push_back(r);
        plan_set[{row, col}] = 1'b1;
        queued++;
    endfunction

    function automatic void queue_noise();
        t_lof_request r;
        r.op = OP_UNUSED;
        r.row = IDX_BITS'($urandom_range(0, 127));
        r.col = IDX_BITS'($urandom_range(0, 127));
        r.weight = $urandom;
        r.gene = IDX_BITS'($urandom_range(0, 127));
        r.last_gene = 1'($urandom_range(0, 1));
        pending.push_back(r);
    endfunction

    function automatic void queue_gene(logic [OP_BITS-1:0] op, logic [IDX_BITS-1:0] gene,
                                       logic mark);
        t_lof_request        r;
        int                  span;
        logic [POS_BITS-1:0] a;
        logic [POS_BITS-1:0] b;
        if (op == lof_pkg::OP_DIRECT) begin
            if (plan_count < MAX_N) plan_order[plan_count[IDX_BITS-1:0]] = {1'b0, gene};
        end else begin
            plan_order[gene] = plan_count;
        end
        if (plan_count != 8'hff) plan_count++;
        if (mark) begin
            // load any weight the scoring pass will touch that was never written
            span = (plan_size > MAX_N) ? MAX_N : plan_size;
            for (int i = 0; i + 1 < span; i++)
                for (int j = i + 1; j < span; j++) begin
                    a = plan_order[i];
                    b = plan_order[j];
                    if (a < MAX_N && b < MAX_N && !plan_set[{a[IDX_BITS-1:0], b[IDX_BITS-1:0]}])
                        queue_entry(a[IDX_BITS-1:0], b[IDX_BITS-1:0], fill_weight(),
                                    1'($urandom_range(0, 1)));
                end
            plan_count = '0;
        end
        r.op = op;
        r.row = IDX_BITS'($urandom_range(0, 127));
        r.col = IDX_BITS'($urandom_range(0, 127));
        r.weight = $urandom;
        r.gene = gene;
        r.last_gene = mark;
        pending.push_back(r);
        queued++;
    endfunction

    function automatic void shuffle(int n);
        logic [IDX_BITS-1:0] t;
        int                  k;
        for (int i = 0; i < n; i++) perm_buf[i] = i[IDX_BITS-1:0];
        for (int i = n - 1; i > 0; i--) begin
            k = $urandom_range(0, i);
            t = perm_buf[i];
            perm_buf[i] = perm_buf[k];
            perm_buf[k] = t;
        end
    endfunction

    // one permutation: mostly well formed, sometimes short, long or repeating
    function automatic void run_sequence(int sz);
        int                 span;
        int                 len;
        logic [OP_BITS-1:0] op;
        bit                 wellformed;
        span = (sz > MAX_N) ? MAX_N : sz;
        wellformed = ($urandom_range(0, 9) < 7) && span >= 2;
        op = $urandom_range(0, 1) ? lof_pkg::OP_DIRECT : lof_pkg::OP_INVERSE;
        if (wellformed) begin
            len = span;
            shuffle(span);
        end else begin
            len = $urandom_range(1, (span + 3 > MAX_N) ? MAX_N : span + 3);
        end
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 5) == 0)
                queue_entry(IDX_BITS'($urandom_range(0, 127)), IDX_BITS'($urandom_range(0, 127)),
                            $urandom, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 19) == 0) queue_noise();
            if (!wellformed) op = $urandom_range(0, 1) ? lof_pkg::OP_DIRECT : lof_pkg::OP_INVERSE;
            queue_gene(op, wellformed ? perm_buf[k] : IDX_BITS'($urandom_range(0, 127)),
                       k == len - 1);
        end
    endfunction

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending.size() != 0 || s_axis_tvalid || fitness_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_size(logic [SIZE_BITS-1:0] sz);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= sz;
        do @(negedge i_clk); while (!cfg_fire);
        i_cfg_valid <= 1'b0;
        plan_size = sz;
    endtask

    // sampling side: configuration, taken requests and results
    always @(posedge i_clk) begin
        cfg_fire = i_rst_n && i_cfg_valid && o_cfg_ready;
        in_fire = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (cfg_fire) size_seen = i_cfg_data;
        if (in_fire)
            score_request(s_axis_tuser, s_axis_tdata[lof_pkg::ROW_LSB +: IDX_BITS],
                          s_axis_tdata[lof_pkg::COL_LSB +: IDX_BITS],
                          s_axis_tdata[lof_pkg::VAL_LSB +: VAL_BITS],
                          s_axis_tdata[lof_pkg::GENE_LSB +: IDX_BITS], s_axis_tlast);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (fitness_due.size() == 0) begin
                $display("%0t: fitness with none expected, actual %0d", $time,
                         $signed(m_axis_tdata));
                mismatches++;
            end else begin
                fitness_want = fitness_due.pop_front();
                if (m_axis_tdata !== fitness_want) begin
                    $display("%0t: fitness mismatch, expected %0d actual %0d", $time,
                             $signed(fitness_want), $signed(m_axis_tdata));
                    mismatches++;
                end
            end
        end
    end

    // request driver, bursts with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (gap_left != 0 || pending.size() == 0) begin
                s_axis_tvalid <= 1'b0;
                if (gap_left != 0) gap_left--;
            end else begin
                next_req = pending.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= next_req.op;
                s_axis_tlast <= next_req.last_gene;
                s_axis_tdata <= {3'b000, next_req.gene, next_req.weight, next_req.col,
                                 next_req.row};
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    // result receiver, switches between stall patterns, plus one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_armed && hold_count < LONG_HOLD) begin
            hold_count++;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(RX_OPEN, RX_SLOW);
                rx_left = $urandom_range(16, 96);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                RX_OPEN: m_axis_tready <= 1'b1;
                RX_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial begin
        int base;
        int sz;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // fill the whole order store at the reset size, weight at the extreme low
        queue_entry(7'd127, 7'd126, 32'h8000_0000, 1'b1);
        for (int k = 0; k < MAX_N; k++)
            queue_gene(lof_pkg::OP_DIRECT, 7'd127 - k[IDX_BITS-1:0], k == MAX_N - 1);
        queue_noise();
        queue_entry(7'd127, 7'd127, 32'h7fff_ffff, 1'b1);
        queue_entry(7'd0, 7'd0, 32'h8000_0000, 1'b0);

        write_size(8'd3);
        queue_entry(7'd0, 7'd1, 32'h7fff_ffff, 1'b0);
        queue_entry(7'd0, 7'd2, 32'h7fff_ffff, 1'b0);
        queue_entry(7'd1, 7'd2, 32'h7fff_ffff, 1'b0);
        queue_entry(7'd2, 7'd1, 32'h8000_0000, 1'b0);
        queue_entry(7'd2, 7'd0, 32'h8000_0000, 1'b0);
        queue_entry(7'd1, 7'd0, 32'h8000_0000, 1'b0);
        for (int k = 0; k < 3; k++) queue_gene(lof_pkg::OP_DIRECT, k[IDX_BITS-1:0], k == 2);
        for (int k = 0; k < 3; k++)
            queue_gene(lof_pkg::OP_INVERSE, 7'd2 - k[IDX_BITS-1:0], k == 2);
        queue_noise();

        // sizes too small to have any pair
        write_size(8'd0);
        queue_gene(lof_pkg::OP_DIRECT, 7'd5, 1'b1);
        write_size(8'd1);
        queue_gene(lof_pkg::OP_INVERSE, 7'd0, 1'b1);

        // element count runs past its saturation point
        write_size(8'd4);
        for (int k = 0; k < 300; k++)
            queue_gene(lof_pkg::OP_DIRECT, IDX_BITS'($urandom_range(0, 127)), k == 299);

        // long receiver stall while requests keep coming
        write_size(8'd3);
        hold_armed = 1'b1;
        repeat (8) run_sequence(3);

        base = queued;
        while (queued < base + RANDOM_ITEMS) begin
            case ($urandom_range(0, 19))
                0: sz = $urandom_range(0, 1);
                1, 2: sz = $urandom_range(13, 24);
                default: sz = $urandom_range(2, 12);
            endcase
            write_size(sz[SIZE_BITS-1:0]);
            repeat ($urandom_range(3, 8)) run_sequence(sz);
        end

        // largest size; inverse requests past position 127 push most elements out of range
        write_size(8'd128);
        shuffle(MAX_N);
        for (int k = 0; k < MAX_N; k++) queue_gene(lof_pkg::OP_DIRECT, perm_buf[k], 1'b0);
        for (int k = 0; k < MAX_N - 8; k++)
            queue_gene(lof_pkg::OP_INVERSE, perm_buf[k], k == MAX_N - 9);
        // oversized setting over nearly the same ordering
        write_size(8'd255);
        queue_gene(lof_pkg::OP_INVERSE, perm_buf[0], 1'b1);

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && fitness_due.size() == 0) begin
            $display("linear_ordering_fitness verification clean");
        end else begin
            $display("linear_ordering_fitness verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("linear_ordering_fitness verification failed");
        $finish;
    end

endmodule
